### hdl/cos_pkg.sv
// ---------------------------------------------------------------------------
// cos_pkg
// Shared types, sizes and helpers for the complement overlap scan core.
// ---------------------------------------------------------------------------
package cos_pkg;

    localparam int TARGET_LEN = 20;
    localparam int TGT_W      = 2 * TARGET_LEN;
    localparam int CNT_W      = $clog2(TARGET_LEN + 1);
    localparam int OUT_W      = 5;
    localparam int OUT_MAX    = (1 << OUT_W) - 1;
    // One leaf per cell plus one for the folded best of finished shifts.
    localparam int NUM_LEAF   = TARGET_LEN + 1;
    localparam int LEVELS     = $clog2(NUM_LEAF);

    // Two bases pair when they differ only in the low bit.
    localparam logic [1:0] PAIR_XOR = 2'b01;

    typedef struct packed {
        logic [1:0] base;
        logic       last_base;
    } cos_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] best_run;
        logic [OUT_W-1:0] best_total;
    } cos_out_t;

    typedef struct packed {
        logic [CNT_W-1:0] run;
        logic [CNT_W-1:0] best;
        logic [CNT_W-1:0] total;
    } cos_cnt_t;

    typedef struct packed {
        logic [CNT_W-1:0] best_run;
        logic [CNT_W-1:0] total;
    } cos_score_t;

    function automatic logic [CNT_W-1:0] cnt_max(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic cos_score_t score_max(input cos_score_t a, input cos_score_t b);
        cos_score_t r;
        r.best_run = cnt_max(a.best_run, b.best_run);
        r.total    = cnt_max(a.total, b.total);
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] clip_out(input logic [CNT_W-1:0] v);
        if (32'(v) > OUT_MAX)
            return OUT_W'(OUT_MAX);
        else
            return OUT_W'(v);
    endfunction

    // Number of live entries at a given level of the reduction tree.
    function automatic int leaf_cnt(input int lvl);
        return (NUM_LEAF + (1 << lvl) - 1) >> lvl;
    endfunction

endpackage

### hdl/complement_overlap_scan_core.sv
// ---------------------------------------------------------------------------
// complement_overlap_scan_core
// Scores a streamed strand of bases against a configured target strand over
// every relative shift and reports the best run and best pair count.
// ---------------------------------------------------------------------------
// Usage:
//   The target strand is written through cfg_wr_en / cfg_wr_data while the
//   block is idle; base t sits in bits 2t+1..2t.
//   The input channel carries one base per item, with last_base set on the
//   final base of a strand. The output channel carries one item per strand.
//   Throughput is one base per cycle: a row of cells, one per target base,
//   moves every shift one target position on with each accepted item.
//   On the final base the cells' updated counts are snapshot into a
//   registered maximum tree and the cells are cleared, so the next strand
//   may begin in the following cycle. The result is presented once the
//   snapshot has passed through every registered level of that tree.
//   When the receiver stalls, the tree holds its items level by level; input
//   is refused whenever every tree level is full, and ordinary bases are
//   refused then as well, as ready is shared.
//   Reset clears the target to zero, all counts and the tree's valid bits.
// ---------------------------------------------------------------------------
module complement_overlap_scan_core
    import cos_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cos_in_t          in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output cos_out_t         out_item,
    input  logic             cfg_wr_en,
    input  logic [TGT_W-1:0] cfg_wr_data
);

    logic [TGT_W-1:0]          target_reg;
    logic                      acc;
    logic                      finish;
    cos_cnt_t                  cell_reg  [0:TARGET_LEN-1];
    cos_cnt_t                  cell_next [0:TARGET_LEN-1];
    logic [CNT_W-1:0]          overall_run_reg;
    logic [CNT_W-1:0]          overall_total_reg;
    cos_score_t [NUM_LEAF-1:0] leaves;

    assign acc    = in_valid && in_ready;
    assign finish = acc && in_item.last_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= '0;
        else if (cfg_wr_en)
            target_reg <= cfg_wr_data;
    end

    genvar k;
    generate
        for (k = 0; k < TARGET_LEN; k++)
        begin : g_cell
            cos_cnt_t prev;
            if (k == 0)
            begin : g_first
                assign prev = '0;
            end
            else
            begin : g_rest
                assign prev = cell_reg[k-1];
            end

            cos_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .step     (acc),
                .clear    (in_item.last_base),
                .tgt_base (target_reg[2*k +: 2]),
                .base     (in_item.base),
                .prev     (prev),
                .cnt_next (cell_next[k]),
                .cnt_reg  (cell_reg[k])
            );

            assign leaves[k].best_run = cell_next[k].best;
            assign leaves[k].total    = cell_next[k].total;
        end
    endgenerate

    // Shifts leaving the far end of the row are folded into the overall best.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overall_run_reg   <= '0;
            overall_total_reg <= '0;
        end
        else if (acc)
        begin
            if (in_item.last_base)
            begin
                overall_run_reg   <= '0;
                overall_total_reg <= '0;
            end
            else
            begin
                overall_run_reg   <= cnt_max(overall_run_reg,
                                             cell_next[TARGET_LEN-1].best);
                overall_total_reg <= cnt_max(overall_total_reg,
                                             cell_next[TARGET_LEN-1].total);
            end
        end
    end

    assign leaves[TARGET_LEN].best_run = overall_run_reg;
    assign leaves[TARGET_LEN].total    = overall_total_reg;

    cos_max_tree u_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && in_item.last_base),
        .in_ready  (in_ready),
        .leaves    (leaves),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (overall_run_reg == '0) && (overall_total_reg == '0)
                   && (cell_reg[0] == '0) && (cell_reg[TARGET_LEN-1] == '0))
        else $error("counts not cleared after the final base");

    a_overall_order: assert property (@(posedge clk) disable iff (!rst_n)
        overall_run_reg <= overall_total_reg)
        else $error("overall best run exceeds overall pair count");

endmodule

### hdl/cos_cell.sv
// ---------------------------------------------------------------------------
// cos_cell
// One position of the target strand: scores the shift whose current base
// faces this target base and hands its counts on to the next cell.
// ---------------------------------------------------------------------------
module cos_cell
    import cos_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       clear,
    input  logic [1:0] tgt_base,
    input  logic [1:0] base,
    input  cos_cnt_t   prev,
    output cos_cnt_t   cnt_next,
    output cos_cnt_t   cnt_reg
);

    logic pair;

    assign pair = ((tgt_base ^ base) == PAIR_XOR);

    always_comb
    begin
        cnt_next.run   = pair ? CNT_W'(prev.run + 1'b1) : '0;
        cnt_next.best  = cnt_max(cnt_next.run, prev.best);
        cnt_next.total = CNT_W'(prev.total + {{(CNT_W-1){1'b0}}, pair});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (step)
        begin
            if (clear)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_next;
        end
    end

    // A shift's best run is never below its current run and never exceeds its pair count.
    a_cell_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg.best >= cnt_reg.run) && (cnt_reg.total >= cnt_reg.best))
        else $error("cell counts out of order");

endmodule

### hdl/cos_max_tree.sv
// ---------------------------------------------------------------------------
// cos_max_tree
// Registered maximum tree over the snapshot of all leaves taken at the final
// base, with a valid and ready pair per level so that it can stall.
// ---------------------------------------------------------------------------
module cos_max_tree
    import cos_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cos_score_t [NUM_LEAF-1:0]    leaves,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cos_out_t                     out_item
);

    cos_score_t         lvl_reg  [0:LEVELS][0:NUM_LEAF-1];
    cos_score_t         lvl_next [1:LEVELS][0:NUM_LEAF-1];
    logic [LEVELS:0]    v_reg;
    logic [LEVELS+1:0]  rdy;

    assign rdy[LEVELS+1] = out_ready;

    genvar l, j;
    generate
        for (l = 0; l <= LEVELS; l++)
        begin : g_rdy
            assign rdy[l] = !v_reg[l] || rdy[l+1];
        end
        for (l = 1; l <= LEVELS; l++)
        begin : g_lvl
            for (j = 0; j < NUM_LEAF; j++)
            begin : g_ent
                if (2 * j + 1 < leaf_cnt(l - 1))
                begin : g_pair
                    assign lvl_next[l][j] = score_max(lvl_reg[l-1][2*j],
                                                      lvl_reg[l-1][2*j+1]);
                end
                else if (2 * j < leaf_cnt(l - 1))
                begin : g_pass
                    assign lvl_next[l][j] = lvl_reg[l-1][2*j];
                end
                else
                begin : g_none
                    assign lvl_next[l][j] = '0;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i <= LEVELS; i++)
            begin
                if (rdy[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int k = 0; k < NUM_LEAF; k++)
                lvl_reg[0][k] <= leaves[k];
        end
        for (int i = 1; i <= LEVELS; i++)
        begin
            if (rdy[i])
            begin
                for (int k = 0; k < NUM_LEAF; k++)
                    lvl_reg[i][k] <= lvl_next[i][k];
            end
        end
    end

    assign in_ready            = rdy[0];
    assign out_valid           = v_reg[LEVELS];
    assign out_item.best_run   = clip_out(lvl_reg[LEVELS][0].best_run);
    assign out_item.best_total = clip_out(lvl_reg[LEVELS][0].total);

    // The tree only refuses an item when every level holds one.
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !rdy[0] |-> ($countones(v_reg) == LEVELS + 1))
        else $error("tree blocks input with a free level");

    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.best_run <= out_item.best_total))
        else $error("best run exceeds best pair count");

endmodule

### tb/sv/complement_overlap_scan_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// complement_overlap_scan_core_test
// Streams strands of bases into the scan core under random idling on both
// channels and checks every best-run / best-pair-count item against a
// cycle-free scoring model kept alongside, after a short directed table.
// ---------------------------------------------------------------------------
module complement_overlap_scan_core_test;
    import cos_pkg::*;

    localparam int ITEM_GOAL   = 1125;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [TGT_W-1:0] TGT_ALL_ONES = '1;

    typedef struct {
        bit               new_tgt;
        logic [TGT_W-1:0] tgt;
        logic [1:0]       base;
        logic             last_base;
        bit               fixed;
        cos_out_t         score;
    } strand_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    cos_in_t          in_item;
    logic             out_valid;
    logic             out_ready;
    cos_out_t         out_item;
    logic             cfg_wr_en;
    logic [TGT_W-1:0] cfg_wr_data;

    // Scoring model state: one entry per target position.
    logic [TGT_W-1:0] scan_target;
    bit [CNT_W-1:0]   cell_run   [TARGET_LEN];
    bit [CNT_W-1:0]   cell_peak  [TARGET_LEN];
    bit [CNT_W-1:0]   cell_pairs [TARGET_LEN];
    bit [CNT_W-1:0]   done_run;
    bit [CNT_W-1:0]   done_pairs;

    cos_out_t    pending_scores[$];
    strand_row_t strand_rows[$];
    int          n_sent;
    int          n_errors;
    int          idle_cycles;
    bit          holding;

    complement_overlap_scan_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #2 clk = ~clk;

    function automatic bit calm_window();
        return (n_sent >= 600) && (n_sent < 800);
    endfunction

    function automatic void absorb_cell(input int k);
        if (cell_peak[k] > done_run)
            done_run = cell_peak[k];
        if (cell_pairs[k] > done_pairs)
            done_pairs = cell_pairs[k];
    endfunction

    function automatic logic [OUT_W-1:0] saturate(input bit [CNT_W-1:0] v);
        return (int'(v) > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(v);
    endfunction

    // Moves every shift one target position on; returns 1 with a score at
    // the end of a strand.
    function automatic bit score_base(input logic [1:0] b, input logic last_b,
                                      output cos_out_t score);
        bit [CNT_W-1:0] prun;
        bit [CNT_W-1:0] ppeak;
        bit [CNT_W-1:0] ppairs;
        bit [CNT_W-1:0] run;
        bit             hit;
        score = '0;
        for (int k = TARGET_LEN - 1; k >= 0; k--)
        begin
            prun   = (k > 0) ? cell_run[k-1]   : '0;
            ppeak  = (k > 0) ? cell_peak[k-1]  : '0;
            ppairs = (k > 0) ? cell_pairs[k-1] : '0;
            hit    = ((scan_target[2*k +: 2] ^ b) == PAIR_XOR);
            run    = hit ? prun + 1'b1 : '0;
            cell_run[k]   = run;
            cell_peak[k]  = (run > ppeak) ? run : ppeak;
            cell_pairs[k] = ppairs + hit;
        end
        // The shift that has just met the final target base is complete.
        absorb_cell(TARGET_LEN - 1);
        if (!last_b)
            return 1'b0;
        for (int k = 0; k < TARGET_LEN; k++)
            absorb_cell(k);
        score.best_run   = saturate(done_run);
        score.best_total = saturate(done_pairs);
        for (int k = 0; k < TARGET_LEN; k++)
        begin
            cell_run[k]   = '0;
            cell_peak[k]  = '0;
            cell_pairs[k] = '0;
        end
        done_run   = '0;
        done_pairs = '0;
        return 1'b1;
    endfunction

    task automatic push_base(input logic [1:0] b, input logic last_b, input bit fixed,
                             input cos_out_t fixed_score);
        cos_out_t score;
        while (!calm_window() && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_item.base      <= b;
        in_item.last_base <= last_b;
        do
            @(posedge clk);
        while (!in_ready);
        n_sent++;
        if (score_base(b, last_b, score))
            pending_scores.push_back(fixed ? fixed_score : score);
    endtask

    // The target may only change once the core has drained.
    task automatic write_target(input logic [TGT_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        scan_target = value;
    endtask

    function automatic void add_row(input bit new_tgt, input logic [TGT_W-1:0] tgt,
                                    input logic [1:0] b, input logic last_b,
                                    input bit fixed, input int exp_run,
                                    input int exp_total);
        strand_row_t row;
        row.new_tgt          = new_tgt;
        row.tgt              = tgt;
        row.base             = b;
        row.last_base        = last_b;
        row.fixed            = fixed;
        row.score.best_run   = OUT_W'(exp_run);
        row.score.best_total = OUT_W'(exp_total);
        strand_rows.push_back(row);
    endfunction

    // Result side: random back-pressure plus one long hold-off.
    initial
    begin
        cos_out_t want;
        bit       held;
        out_ready = 1'b0;
        held      = 1'b0;
        holding   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_scores.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: unexpected item best_run=%0d best_total=%0d",
                                 out_item.best_run, out_item.best_total);
                end
                else
                begin
                    want = pending_scores.pop_front();
                    if (out_item.best_run !== want.best_run
                        || out_item.best_total !== want.best_total)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("ERROR: best_run exp %0d got %0d, best_total exp %0d got %0d",
                                     want.best_run, out_item.best_run,
                                     want.best_total, out_item.best_total);
                    end
                end
            end
            if (!held && n_sent >= 350)
            begin
                held      = 1'b1;
                holding   = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding   = 1'b0;
                out_ready <= 1'b1;
            end
            else
                out_ready <= calm_window() || ($urandom_range(99) >= 9);
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        cos_out_t         no_score;
        logic [TGT_W-1:0] tgt;
        logic [1:0]       b;
        int               len;
        int               offset;
        bit               guided;

        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        n_sent      = 0;
        n_errors    = 0;
        no_score    = '0;
        scan_target = '0;
        for (int k = 0; k < TARGET_LEN; k++)
        begin
            cell_run[k]   = '0;
            cell_peak[k]  = '0;
            cell_pairs[k] = '0;
        end
        done_run   = '0;
        done_pairs = '0;

        // Target is all zero after reset, so a lone base 1 pairs everywhere.
        add_row(1'b0, '0, 2'd1, 1'b1, 1'b1, 1, 1);
        add_row(1'b0, '0, 2'd0, 1'b1, 1'b1, 0, 0);
        add_row(1'b0, '0, 2'd2, 1'b0, 1'b0, 0, 0);
        add_row(1'b0, '0, 2'd3, 1'b1, 1'b1, 0, 0);
        add_row(1'b1, TGT_ALL_ONES, 2'd3, 1'b1, 1'b1, 0, 0);
        // A full-length strand of 2s against an all-3 target pairs throughout.
        for (int i = 0; i < TARGET_LEN; i++)
            add_row(1'b0, '0, 2'd2, i == TARGET_LEN - 1, i == TARGET_LEN - 1,
                    TARGET_LEN, TARGET_LEN);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (strand_rows[i])
        begin
            if (strand_rows[i].new_tgt)
                write_target(strand_rows[i].tgt);
            push_base(strand_rows[i].base, strand_rows[i].last_base,
                      strand_rows[i].fixed, strand_rows[i].score);
        end

        while (n_sent < ITEM_GOAL)
        begin
            if (!holding && $urandom_range(7) == 0)
            begin
                case ($urandom_range(5))
                    0: tgt = '0;
                    1: tgt = TGT_ALL_ONES;
                    2: tgt = {TARGET_LEN{2'b01}};
                    default: tgt = {8'($urandom()), $urandom()};
                endcase
                write_target(tgt);
            end
            case ($urandom_range(9))
                0: len = 1;
                1: len = TARGET_LEN;
                2, 3, 4: len = $urandom_range(TARGET_LEN - 1, 1);
                5, 6, 7: len = $urandom_range(2 * TARGET_LEN + 5, TARGET_LEN + 1);
                default: len = $urandom_range(8, 2);
            endcase
            // Most strands follow the complement of the target so that long
            // runs and full overlaps occur, with occasional stray bases.
            guided = ($urandom_range(9) < 6);
            offset = $urandom_range(TARGET_LEN - 1);
            for (int i = 0; i < len; i++)
            begin
                if (guided && $urandom_range(11) != 0)
                    b = scan_target[2*((i + offset) % TARGET_LEN) +: 2] ^ PAIR_XOR;
                else
                    b = 2'($urandom_range(3));
                push_base(b, i == len - 1, 1'b0, no_score);
            end
        end
        in_valid <= 1'b0;

        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hdl/cos_pkg.sv
hdl/cos_cell.sv
hdl/cos_max_tree.sv
hdl/complement_overlap_scan_core.sv
tb/sv/complement_overlap_scan_core_test.sv
